[src/mecs_pkg.sv]
// Shared types and constants of the multi-channel encoder counter.
package mecs_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] OP_EDGE   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_GATE     = 2'd0;
  localparam logic [1:0] REG_MOTOR_PPR = 2'd1;
  localparam logic [1:0] REG_JACK_PPR  = 2'd2;
  localparam logic [1:0] REG_INVERT    = 2'd3;

  // Register reset values.
  localparam logic [15:0] GATE_RESET = 16'd100;
  localparam logic [15:0] PPR_RESET  = 16'd1024;

  // Scale factors.
  localparam logic [9:0] MS_PER_S  = 10'd1000;
  localparam logic [5:0] S_PER_MIN = 6'd60;

  // Shared divider: dividend width and step counts of the two divisions.
  localparam int DVD_W      = 41;
  localparam int DIV1_STEPS = 41;
  localparam int DIV2_STEPS = 32;
  localparam int STEP_W     = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MUL1,
    S_DIV1,
    S_FIX1,
    S_MUL2,
    S_PREP2,
    S_DIV2,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

[src/multi_encoder_count_and_speed.sv]
// Multi-channel quadrature encoder counter with gated speed and rpm measurement.
//
// Input beats arrive on s_tvalid/s_tready; s_tuser carries the operation and
// channel, s_tdata the phase B level and the elapsed milliseconds of a tick.
// Every input beat yields one output beat on m_tvalid/m_tready with the
// addressed channel's count, pulses per second and rpm.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, and the block itself does not enforce this.
// An edge, clear or unused operation passes from idle to the done state,
// which loads the output register once it is free. A tick scans every
// channel; for each whose gate period has run out, the measurement runs
// two divisions (41 and 32 steps) through one shared restoring divider.
// One item is processed at a time; s_tready is high only while the sequencer
// is idle. A finished result sits in the output register, so the next item
// is taken while that result still waits. When the receiver stalls and the
// output register is full, the next result waits in the sequencer.
// Reset (synchronous, active high) zeroes all counts, speeds, times and the
// millisecond clock and loads the register defaults.
module multi_encoder_count_and_speed import mecs_pkg::*; #(
  parameter int MOTOR_CHANNELS = 2,
  parameter int JACK_CHANNELS  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // phase_b_level[0], elapsed_ms[16:1], zero pad
  input  logic [3:0]  s_tuser,   // operation[1:0], channel[3:2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // pulse_count[31:0], speed_pps[63:32], speed_rpm[95:64]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TOTAL = MOTOR_CHANNELS + JACK_CHANNELS;
  localparam int CW    = $clog2(TOTAL);

  // Configuration registers.
  logic [15:0] gate_period_ms;
  logic [15:0] motor_ppr;
  logic [15:0] jack_ppr;
  logic [3:0]  invert_mask;

  // Channel state.
  logic [31:0] count_store [TOTAL];
  logic [31:0] prev_store  [TOTAL];
  logic [31:0] pps_store   [TOTAL];
  logic [31:0] rpm_store   [TOTAL];
  logic [31:0] last_time   [TOTAL];
  logic [31:0] clock_ms;

  // Sequencer and datapath registers.
  state_t            state, state_next;
  logic [CW-1:0]     idx;
  logic [1:0]        in_ch;
  logic [STEP_W-1:0] steps;
  logic              neg;
  logic [31:0]       mag;
  logic [31:0]       divisor;
  logic [31:0]       rem;
  logic [DVD_W-1:0]  dvd;
  logic [31:0]       pps_r;
  logic [31:0]       scaled;
  logic              out_valid;
  logic [95:0]       out_data;

  // Control strobes.
  logic accept;
  logic load_out;

  // Input fields.
  logic [1:0]  s_op;
  logic [1:0]  s_ch;
  logic        s_b;
  logic [15:0] s_el;

  assign s_op = s_tuser[1:0];
  assign s_ch = s_tuser[3:2];
  assign s_b  = s_tdata[0];
  assign s_el = s_tdata[16:1];
  assign accept = s_tvalid && s_tready;

  // Single read address into the channel state.
  logic [CW-1:0] rd_idx;
  logic [31:0]   rd_count, rd_prev, rd_pps, rd_rpm, rd_last;

  always_comb begin
    if (state == S_IDLE) begin
      rd_idx = CW'(s_ch);
    end else if (state == S_DONE) begin
      rd_idx = CW'(in_ch);
    end else begin
      rd_idx = idx;
    end
  end

  assign rd_count = count_store[rd_idx];
  assign rd_prev  = prev_store[rd_idx];
  assign rd_pps   = pps_store[rd_idx];
  assign rd_rpm   = rpm_store[rd_idx];
  assign rd_last  = last_time[rd_idx];

  // Channel checks.
  logic s_ch_ok, in_ch_ok, idx_last, idx_motor, down;
  assign s_ch_ok   = (32'(s_ch) < 32'(TOTAL));
  assign in_ch_ok  = (32'(in_ch) < 32'(TOTAL));
  assign idx_last  = (idx == CW'(TOTAL - 1));
  assign idx_motor = (32'(idx) < 32'(MOTOR_CHANNELS));
  assign down      = s_b ^ invert_mask[s_ch];

  // Gate check and pulse delta of the scanned channel.
  logic [31:0] dt, dp;
  logic [15:0] gate_eff, ppr_sel, ppr_eff;
  logic        measure;
  assign dt       = clock_ms - rd_last;
  assign dp       = rd_count - rd_prev;
  assign gate_eff = (gate_period_ms == 16'd0) ? 16'd1 : gate_period_ms;
  assign measure  = (dt >= {16'd0, gate_eff});
  assign ppr_sel  = idx_motor ? motor_ppr : jack_ppr;
  assign ppr_eff  = (ppr_sel == 16'd0) ? 16'd1 : ppr_sel;

  // Multipliers by the scale constants.
  logic [41:0] prod1;
  logic [37:0] prod2;
  assign prod1 = {10'd0, mag} * {32'd0, MS_PER_S};
  assign prod2 = {6'd0, pps_r} * {32'd0, S_PER_MIN};

  // One restoring divider step.
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] rem_new;
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, divisor});
  assign rem_new = ge ? 32'(rem_sh - {1'b0, divisor}) : rem_sh[31:0];

  // Signed quotient from magnitude.
  logic [31:0] q_signed;
  assign q_signed = neg ? (32'd0 - dvd[31:0]) : dvd[31:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = (s_op == OP_TICK) ? S_SCAN : S_DONE;
      S_SCAN: begin
        if (measure) begin
          state_next = S_MUL1;
        end else if (idx_last) begin
          state_next = S_DONE;
        end
      end
      S_MUL1:  state_next = S_DIV1;
      S_DIV1:  if (steps == STEP_W'(DIV1_STEPS - 1)) state_next = S_FIX1;
      S_FIX1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_PREP2;
      S_PREP2: state_next = S_DIV2;
      S_DIV2:  if (steps == STEP_W'(DIV2_STEPS - 1)) state_next = S_WRITE;
      S_WRITE: state_next = idx_last ? S_DONE : S_SCAN;
      S_DONE:  if (!out_valid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake strobes.
  always_comb begin
    s_tready = (state == S_IDLE);
    load_out = (state == S_DONE) && (!out_valid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes, output register and channel state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_period_ms <= GATE_RESET;
      motor_ppr      <= PPR_RESET;
      jack_ppr       <= PPR_RESET;
      invert_mask    <= 4'd0;
      out_valid      <= 1'b0;
      clock_ms       <= 32'd0;
      idx            <= '0;
      for (int i = 0; i < TOTAL; i++) begin
        count_store[i] <= 32'd0;
        prev_store[i]  <= 32'd0;
        pps_store[i]   <= 32'd0;
        rpm_store[i]   <= 32'd0;
        last_time[i]   <= 32'd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GATE:      gate_period_ms <= cfg_data;
          REG_MOTOR_PPR: motor_ppr      <= cfg_data;
          REG_JACK_PPR:  jack_ppr       <= cfg_data;
          REG_INVERT:    invert_mask    <= cfg_data[3:0];
          default:       ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            in_ch <= s_ch;
            idx   <= '0;
            if (s_op == OP_EDGE && s_ch_ok) begin
              count_store[rd_idx] <= down ? (rd_count - 32'd1) : (rd_count + 32'd1);
            end else if (s_op == OP_TICK) begin
              clock_ms <= clock_ms + {16'd0, s_el};
            end else if (s_op == OP_CLEAR && s_ch_ok) begin
              count_store[rd_idx] <= 32'd0;
              prev_store[rd_idx]  <= 32'd0;
              pps_store[rd_idx]   <= 32'd0;
              rpm_store[rd_idx]   <= 32'd0;
              last_time[rd_idx]   <= clock_ms;
            end
          end
        end
        S_SCAN: begin
          divisor <= dt;
          neg     <= dp[31];
          mag     <= dp[31] ? (32'd0 - dp) : dp;
          if (!measure && !idx_last) begin
            idx <= idx + CW'(1);
          end
        end
        S_MUL1: begin
          dvd   <= prod1[DVD_W-1:0];
          rem   <= 32'd0;
          steps <= '0;
        end
        S_DIV1, S_DIV2: begin
          rem   <= rem_new;
          dvd   <= {dvd[DVD_W-2:0], ge};
          steps <= steps + STEP_W'(1);
        end
        S_FIX1: begin
          pps_r <= q_signed;
        end
        S_MUL2: begin
          scaled <= prod2[31:0];
        end
        S_PREP2: begin
          neg     <= scaled[31];
          dvd     <= {(scaled[31] ? (32'd0 - scaled) : scaled), 9'd0};
          rem     <= 32'd0;
          steps   <= '0;
          divisor <= {16'd0, ppr_eff};
        end
        S_WRITE: begin
          pps_store[idx]  <= pps_r;
          rpm_store[idx]  <= q_signed;
          prev_store[idx] <= rd_count;
          last_time[idx]  <= clock_ms;
          if (!idx_last) begin
            idx <= idx + CW'(1);
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_data <= in_ch_ok ? {rd_rpm, rd_pps, rd_count} : 96'd0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

`ifndef SYNTHESIS
  // A new result is loaded only at the end of an item.
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("output valid rose outside the done state");

  // The block takes no second item right behind an accepted one.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while busy");

  // The clock only moves after a tick is accepted.
  a_clock_tick: assert property (@(posedge clk) disable iff (rst)
    !$stable(clock_ms) |-> $past(accept && s_op == OP_TICK))
    else $error("millisecond clock moved without a tick");
`endif

endmodule
